// ===== design/two_link_inverse_kinematics_unit_macros.svh =====
// Assertion macros for the two-link inverse kinematics unit
`ifndef TWO_LINK_INVERSE_KINEMATICS_UNIT_MACROS_SVH
`define TWO_LINK_INVERSE_KINEMATICS_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define TLIK_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TLIK_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define TLIK_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define TLIK_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== design/tlik_pkg.sv =====
// ----------------------------------------------------------------------------
// tlik_pkg
// Types, constants and tables shared by the inverse kinematics unit.
// ----------------------------------------------------------------------------
package tlik_pkg;

    localparam int CORDIC_ITERATIONS_DEFAULT = 16;
    localparam int CORDIC_MAX = 24;
    localparam int LINK_W = 14;
    localparam int COORD_W = 16;
    localparam int HIP_W = 17;
    localparam int ELBOW_W = 16;
    localparam int REG_IDX_W = 8;
    localparam int CFG_DATA_W = 14;
    localparam int ANG_W = 26;
    localparam int VEC_W = 64;

    localparam logic [REG_IDX_W-1:0] REG_UPPER = 8'd0;
    localparam logic [REG_IDX_W-1:0] REG_LOWER = 8'd1;

    localparam logic signed [ANG_W-1:0] DEG90 = 26'sd2949120;
    localparam logic signed [ANG_W-1:0] DEG180 = 26'sd5898240;
    localparam logic [ELBOW_W-1:0] ELBOW_OFFSET = 16'd23040;

    // datapath operation codes
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQRT_STEP,
        OP_ATAN_SEL,
        OP_NORM_STEP,
        OP_CORDIC_STEP,
        OP_ATAN_DONE,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] which;   // which atan2 is being worked on
        logic [4:0] step;
    } dp_cmd_t;

    typedef struct packed {
        logic out_of_reach;
        logic norm_done;
    } dp_status_t;

    function automatic logic [ANG_W-1:0] atan_entry(input logic [4:0] i);
        logic [ANG_W-1:0] r;
        begin
            case (i)
                5'd0: r = 26'd1474560;
                5'd1: r = 26'd870484;
                5'd2: r = 26'd459940;
                5'd3: r = 26'd233473;
                5'd4: r = 26'd117189;
                5'd5: r = 26'd58652;
                5'd6: r = 26'd29333;
                5'd7: r = 26'd14667;
                5'd8: r = 26'd7334;
                5'd9: r = 26'd3667;
                5'd10: r = 26'd1833;
                5'd11: r = 26'd917;
                5'd12: r = 26'd458;
                5'd13: r = 26'd229;
                5'd14: r = 26'd115;
                5'd15: r = 26'd57;
                5'd16: r = 26'd29;
                5'd17: r = 26'd14;
                5'd18: r = 26'd7;
                5'd19: r = 26'd4;
                5'd20: r = 26'd2;
                5'd21: r = 26'd1;
                default: r = 26'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== design/tlik_if.sv =====
// ----------------------------------------------------------------------------
// tlik_in_if / tlik_out_if / tlik_cfg_if
// Valid/ready channels of the inverse kinematics unit.
// ----------------------------------------------------------------------------
interface tlik_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    modport source (output valid, target_x, target_y, input ready);
    modport sink (input valid, target_x, target_y, output ready);
endinterface

interface tlik_out_if;
    logic valid;
    logic ready;
    logic signed [16:0] joint_one_angle;
    logic [15:0] joint_two_angle;
    logic out_of_reach;
    modport source (output valid, joint_one_angle, joint_two_angle, out_of_reach,
                    input ready);
    modport sink (input valid, joint_one_angle, joint_two_angle, out_of_reach,
                  output ready);
endinterface

interface tlik_cfg_if;
    logic valid;
    logic ready;
    logic [7:0] index;
    logic [13:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== design/two_link_inverse_kinematics_unit.sv =====
// Sequence: load, 32-step root, three atan2 solves with normalise and CORDIC, finish;
// an out of reach target skips the root and the atan2 solves and goes straight to finish.
// Throughput: one target at a time; the next target is taken only after the result is taken;
// the 32-step root has its own logic, and the three atan2 share one CORDIC unit.
// Reset: rst_n asynchronous, active low; links return to 14080, held angles to 0.
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics_unit
// Two-link planar inverse kinematics: target position to hip and elbow angles.
// ----------------------------------------------------------------------------
`include "two_link_inverse_kinematics_unit_macros.svh"
module two_link_inverse_kinematics_unit #(
    parameter int CORDIC_ITERATIONS = tlik_pkg::CORDIC_ITERATIONS_DEFAULT
) (
    input logic clk,
    input logic rst_n,
    tlik_in_if.sink    target,
    tlik_out_if.source joint,
    tlik_cfg_if.sink   cfg
);
    import tlik_pkg::*;

    logic [LINK_W-1:0] l1_reg, l2_reg;
    dp_cmd_t cmd;
    dp_status_t status;
    logic in_ready;

    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_reg <= 14'd14080;
            l2_reg <= 14'd14080;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_UPPER: l1_reg <= cfg.data;
                REG_LOWER: l2_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    tlik_controller #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(target.valid), .in_ready(in_ready),
        .out_valid(joint.valid), .out_ready(joint.ready),
        .cmd(cmd), .status(status)
    );

    tlik_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .in_x(target.target_x), .in_y(target.target_y),
        .l1(l1_reg), .l2(l2_reg),
        .hip_out(joint.joint_one_angle), .elbow_out(joint.joint_two_angle)
    );

    assign target.ready = in_ready;
    assign joint.out_of_reach = status.out_of_reach;

    `TLIK_ASSERT_NEXT(a_accept_busy, clk, rst_n, target.valid && in_ready, !in_ready,
        "input taken while busy")
    `TLIK_ASSERT_IMPL(a_no_overlap, clk, rst_n, !(in_ready && joint.valid),
        "result and accept overlap")
    `TLIK_ASSERT_NEXT(a_hold_result, clk, rst_n, joint.valid && !joint.ready,
        joint.valid && $stable(joint.joint_one_angle), "result dropped")

endmodule

// ===== design/tlik_datapath.sv =====
// ----------------------------------------------------------------------------
// tlik_datapath
// Square root, shared normalise/CORDIC unit and output rounding.
// ----------------------------------------------------------------------------
module tlik_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  tlik_pkg::dp_cmd_t         cmd,
    output tlik_pkg::dp_status_t      status,
    input  logic signed [15:0]        in_x,
    input  logic signed [15:0]        in_y,
    input  logic [13:0]               l1,
    input  logic [13:0]               l2,
    output logic signed [16:0]        hip_out,
    output logic [15:0]               elbow_out
);
    import tlik_pkg::*;

    localparam int MUL_W = 32;

    // Products are split into single-multiplier steps across the load phase.
    logic signed [15:0] x_reg, y_reg;
    logic signed [VEC_W-1:0] n_reg, d_reg, s_reg;
    logic [VEC_W-1:0] rad_reg, root_reg, bit_reg;
    logic signed [VEC_W-1:0] vx_reg, vy_reg;
    logic signed [ANG_W-1:0] z_reg;
    logic vx_neg_reg, vy_neg_reg;
    logic signed [ANG_W+1:0] elbow_ang_reg, hip_acc_reg;
    logic [16:0] held_hip_reg;
    logic [15:0] held_elbow_reg;
    logic oor_reg;
    logic [3:0] ld_reg;
    logic signed [VEC_W-1:0] t1_reg, t2_reg;

    // every operand fits in 32 signed bits once n is clamped
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [VEC_W-1:0] mul_p;
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ld_reg)
            4'd0: begin mul_a = MUL_W'(x_reg); mul_b = MUL_W'(x_reg); end
            4'd1: begin mul_a = MUL_W'(y_reg); mul_b = MUL_W'(y_reg); end
            4'd2: begin mul_a = MUL_W'({1'b0, l1}); mul_b = MUL_W'({1'b0, l1}); end
            4'd3: begin mul_a = MUL_W'({1'b0, l2}); mul_b = MUL_W'({1'b0, l2}); end
            4'd4: begin mul_a = MUL_W'({1'b0, l1}); mul_b = MUL_W'({1'b0, l2}); end
            4'd5: begin mul_a = MUL_W'({1'b0, l1}) + MUL_W'({1'b0, l2});
                        mul_b = mul_a; end
            4'd6: begin mul_a = d_reg[MUL_W-1:0]; mul_b = d_reg[MUL_W-1:0]; end
            4'd7: begin mul_a = n_reg[MUL_W-1:0]; mul_b = n_reg[MUL_W-1:0]; end
            4'd8: begin mul_a = MUL_W'({1'b0, l2}); mul_b = s_reg[MUL_W-1:0]; end
            4'd9: begin mul_a = MUL_W'({1'b0, l1}); mul_b = d_reg[MUL_W-1:0]; end
            4'd10: begin mul_a = MUL_W'({1'b0, l2}); mul_b = n_reg[MUL_W-1:0]; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        mul_p = VEC_W'(mul_a) * VEC_W'(mul_b);
    end

    // atan2 source selection
    logic signed [VEC_W-1:0] src_y, src_x;
    always_comb
    begin
        case (cmd.which)
            2'd0: begin src_y = s_reg; src_x = n_reg; end
            2'd1: begin src_y = VEC_W'(y_reg); src_x = VEC_W'(x_reg); end
            default: begin src_y = t1_reg; src_x = t2_reg; end
        endcase
    end

    logic [VEC_W-1:0] ax, ay, mx;
    logic [VEC_W-1:0] rb;
    always_comb
    begin
        ax = vx_reg;
        ay = vy_reg;
        mx = (ax > ay) ? ax : ay;
        rb = root_reg + bit_reg;
    end

    logic signed [VEC_W-1:0] dx, dy;
    logic [5:0] sh;
    assign sh = {1'b0, cmd.step};
    always_comb
    begin
        dx = vy_reg[VEC_W-1] ? -((-vy_reg) >>> sh) : (vy_reg >>> sh);
        dy = vx_reg[VEC_W-1] ? -((-vx_reg) >>> sh) : (vx_reg >>> sh);
    end

    logic signed [ANG_W+1:0] a_fin;
    always_comb
    begin
        logic signed [ANG_W+1:0] a;
        a = (z_reg < 0) ? '0 : ((z_reg > DEG90) ? (ANG_W+2)'(DEG90) : (ANG_W+2)'(z_reg));
        if (vx_neg_reg) a = (ANG_W+2)'(DEG180) - a;
        if (vy_neg_reg) a = -a;
        a_fin = a;
    end

    function automatic logic signed [16:0] rnd(input logic signed [ANG_W+1:0] v);
        logic [ANG_W+1:0] m;
        logic [ANG_W+1:0] q;
        begin
            m = v[ANG_W+1] ? -v : v;
            q = (m + 128) >> 8;
            return v[ANG_W+1] ? -17'(q) : 17'(q);
        end
    endfunction

    logic signed [16:0] hip_r, elbow_r;
    assign hip_r = rnd(hip_acc_reg - a_fin);
    assign elbow_r = rnd(elbow_ang_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_hip_reg <= '0;
            held_elbow_reg <= '0;
            oor_reg <= 1'b0;
            ld_reg <= '0;
            x_reg <= '0;
            y_reg <= '0;
            n_reg <= '0;
            d_reg <= '0;
            s_reg <= '0;
            rad_reg <= '0;
            root_reg <= '0;
            bit_reg <= '0;
            vx_reg <= '0;
            vy_reg <= '0;
            z_reg <= '0;
            vx_neg_reg <= 1'b0;
            vy_neg_reg <= 1'b0;
            elbow_ang_reg <= '0;
            hip_acc_reg <= '0;
            t1_reg <= '0;
            t2_reg <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_LOAD:
                begin
                    // one product a cycle; the product used at step k is chosen at k-1
                    ld_reg <= cmd.step[3:0];
                    case (cmd.step[3:0])
                        4'd0:
                        begin
                            x_reg <= in_x;
                            y_reg <= in_y;
                        end
                        4'd1: t1_reg <= mul_p;
                        4'd2: t1_reg <= t1_reg + mul_p;
                        4'd3: n_reg <= t1_reg - mul_p;
                        4'd4: n_reg <= n_reg - mul_p;
                        4'd5: d_reg <= mul_p <<< 1;
                        4'd6:
                        begin
                            oor_reg <= t1_reg > mul_p;
                            if (n_reg > d_reg) n_reg <= d_reg;
                            else if (n_reg < -d_reg) n_reg <= -d_reg;
                        end
                        4'd7: rad_reg <= mul_p;
                        4'd8:
                        begin
                            rad_reg <= rad_reg - mul_p;
                            root_reg <= '0;
                            bit_reg <= 64'h4000_0000_0000_0000;
                        end
                        default: ;
                    endcase
                end
                OP_SQRT_STEP:
                begin
                    if (rad_reg >= rb)
                    begin
                        rad_reg <= rad_reg - rb;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                        root_reg <= root_reg >> 1;
                    bit_reg <= bit_reg >> 2;
                    if (cmd.step == 5'd31)
                    begin
                        s_reg <= y_reg[15] ? -((root_reg >> 1) + ((rad_reg >= rb) ? bit_reg : '0))
                                           : ((root_reg >> 1) + ((rad_reg >= rb) ? bit_reg : '0));
                        ld_reg <= 4'd8;
                    end
                end
                OP_ATAN_SEL:
                begin
                    // cmd.step selects the product phase for the third atan2 inputs
                    if (cmd.step == 5'd1) t1_reg <= mul_p;
                    if (cmd.step == 5'd2) t2_reg <= mul_p;
                    if (cmd.step == 5'd3) t2_reg <= t2_reg + mul_p;
                    if (cmd.step == 5'd4)
                    begin
                        vx_neg_reg <= src_x[VEC_W-1];
                        vy_neg_reg <= src_y[VEC_W-1];
                        vx_reg <= src_x[VEC_W-1] ? -src_x : src_x;
                        vy_reg <= src_y[VEC_W-1] ? -src_y : src_y;
                        z_reg <= '0;
                    end
                    ld_reg <= 4'd8 + cmd.step[3:0];
                end
                OP_NORM_STEP:
                begin
                    if (mx != 0 && mx < 64'h100_0000_0000)
                    begin
                        vx_reg <= vx_reg <<< 1;
                        vy_reg <= vy_reg <<< 1;
                    end
                    else if (mx >= 64'h200_0000_0000)
                    begin
                        vx_reg <= vx_reg >>> 1;
                        vy_reg <= vy_reg >>> 1;
                    end
                end
                OP_CORDIC_STEP:
                begin
                    if (mx != 0 || vy_reg != 0)
                    begin
                        if (vy_reg > 0)
                        begin
                            vx_reg <= vx_reg + dx;
                            vy_reg <= vy_reg - dy;
                            z_reg <= z_reg + atan_entry(cmd.step);
                        end
                        else
                        begin
                            vx_reg <= vx_reg - dx;
                            vy_reg <= vy_reg + dy;
                            z_reg <= z_reg - atan_entry(cmd.step);
                        end
                    end
                end
                OP_ATAN_DONE:
                begin
                    case (cmd.which)
                        2'd0: elbow_ang_reg <= a_fin;
                        2'd1: hip_acc_reg <= a_fin;
                        default: ;
                    endcase
                end
                OP_FINISH:
                begin
                    if (!oor_reg)
                    begin
                        held_hip_reg <= hip_r;
                        held_elbow_reg <= 16'(elbow_r) + ELBOW_OFFSET;
                    end
                end
                default: ;
            endcase
        end
    end

    // zero vector marker kept in magnitudes: z stays zero
    assign status.out_of_reach = oor_reg;
    assign status.norm_done = (mx == 0) || (mx >= 64'h100_0000_0000 && mx < 64'h200_0000_0000);
    assign hip_out = held_hip_reg;
    assign elbow_out = held_elbow_reg;

endmodule

// ===== design/tlik_controller.sv =====
// ----------------------------------------------------------------------------
// tlik_controller
// Sequences the load, root, three atan2 solves and the finish.
// ----------------------------------------------------------------------------
module tlik_controller #(
    parameter int CORDIC_ITERATIONS = tlik_pkg::CORDIC_ITERATIONS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tlik_pkg::dp_cmd_t    cmd,
    input  tlik_pkg::dp_status_t status
);
    import tlik_pkg::*;

    localparam int ITER = (CORDIC_ITERATIONS > CORDIC_MAX) ? CORDIC_MAX : CORDIC_ITERATIONS;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_CHECK, S_SQRT, S_SEL, S_NORM, S_CORDIC, S_DONE, S_FINISH, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic [1:0] which_reg, which_next;

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        which_next = which_reg;
        cmd.op = OP_NONE;
        cmd.which = which_reg;
        cmd.step = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.op = OP_LOAD;
                cmd.step = '0;
                if (in_valid)
                begin
                    state_next = S_LOAD;
                    step_next = 5'd1;
                end
            end
            S_LOAD:
            begin
                cmd.op = OP_LOAD;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd6) state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.out_of_reach) state_next = S_FINISH;
                else
                begin
                    cmd.op = OP_LOAD;
                    cmd.step = step_reg;
                    step_next = step_reg + 5'd1;
                    if (step_reg == 5'd8)
                    begin
                        state_next = S_SQRT;
                        step_next = '0;
                    end
                end
            end
            S_SQRT:
            begin
                cmd.op = OP_SQRT_STEP;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd31)
                begin
                    state_next = S_SEL;
                    step_next = '0;
                    which_next = 2'd0;
                end
            end
            S_SEL:
            begin
                cmd.op = OP_ATAN_SEL;
                step_next = step_reg + 5'd1;
                if (which_reg != 2'd2 && step_reg == 5'd0) step_next = 5'd4;
                if (step_reg == 5'd4)
                begin
                    state_next = S_NORM;
                    step_next = '0;
                end
            end
            S_NORM:
            begin
                if (status.norm_done) state_next = S_CORDIC;
                else cmd.op = OP_NORM_STEP;
            end
            S_CORDIC:
            begin
                cmd.op = OP_CORDIC_STEP;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(ITER - 1)) state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.op = OP_ATAN_DONE;
                step_next = '0;
                if (which_reg == 2'd2) state_next = S_FINISH;
                else
                begin
                    which_next = which_reg + 2'd1;
                    state_next = S_SEL;
                end
            end
            S_FINISH:
            begin
                cmd.op = OP_FINISH;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg <= '0;
            which_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            which_reg <= which_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

endmodule
